[hdl/rainbow_ring_pixel_color_unit_macros.svh]
// assertion macros shared by the rainbow ring pixel color unit
// expects clk and rst in scope of every use
`ifndef RAINBOW_RING_PIXEL_COLOR_UNIT_MACROS_SVH
`define RAINBOW_RING_PIXEL_COLOR_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define RRPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define RRPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rrpc_pkg.sv]
// shared types and constants for the rainbow ring pixel color unit
// no dependencies
package rrpc_pkg;

  // field widths
  localparam int unsigned CH_W  = 8;
  localparam int unsigned POS_W = 6;
  localparam int unsigned HUE_W = 8;

  // default ring sizes
  localparam int unsigned OUTER_RING_LEDS_DEF = 60;
  localparam int unsigned INNER_RING_LEDS_DEF = 24;

  // hue wheel and six-sector split
  localparam int unsigned HUE_STEPS   = 256;
  localparam int unsigned SECTOR_SPAN = 43;
  localparam int unsigned REM_SCALE   = 6;
  localparam logic [CH_W-1:0] CH_MAX  = 8'hFF;

  // register reset values
  localparam logic [CH_W-1:0] BRIGHTNESS_RST = 8'd4;
  localparam logic [CH_W-1:0] SATURATION_RST = 8'd255;

  // register index codes
  typedef enum logic {
    REG_BRIGHTNESS = 1'b0,
    REG_SATURATION = 1'b1
  } reg_idx_t;

  // color wheel sector
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [CH_W-1:0] brightness;
    logic [CH_W-1:0] saturation;
  } cfg_t;

  // hue beat between the hue stage and the color stages
  typedef struct packed {
    logic             valid;
    logic [HUE_W-1:0] hue;
  } hue_beat_t;

endpackage

[hdl/rrpc_regs.sv]
// apb register file holding brightness and saturation
// depends on rrpc_pkg
module rrpc_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output rrpc_pkg::cfg_t        cfg
);

  logic [rrpc_pkg::CH_W-1:0] brightness;
  logic [rrpc_pkg::CH_W-1:0] saturation;
  logic                      wr_en;
  rrpc_pkg::reg_idx_t        idx;

  // word index from the address, byte lanes ignored
  assign idx    = rrpc_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= rrpc_pkg::BRIGHTNESS_RST;
      saturation <= rrpc_pkg::SATURATION_RST;
    end else if (wr_en) begin
      case (idx)
        rrpc_pkg::REG_BRIGHTNESS: brightness <= pwdata[rrpc_pkg::CH_W-1:0];
        rrpc_pkg::REG_SATURATION: saturation <= pwdata[rrpc_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      rrpc_pkg::REG_BRIGHTNESS: prdata = 32'(brightness);
      rrpc_pkg::REG_SATURATION: prdata = 32'(saturation);
      default: prdata = '0;
    endcase
  end

  assign cfg.brightness = brightness;
  assign cfg.saturation = saturation;

endmodule

[hdl/rrpc_hue.sv]
// hue stage: position to hue by constant per-ring table, plus frame offset
// depends on rrpc_pkg
module rrpc_hue #(
  parameter int unsigned OUTER_RING_LEDS = rrpc_pkg::OUTER_RING_LEDS_DEF,
  parameter int unsigned INNER_RING_LEDS = rrpc_pkg::INNER_RING_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          ring_select,
  input  logic [rrpc_pkg::POS_W-1:0]    led_position,
  input  logic [rrpc_pkg::HUE_W-1:0]    hue_offset,
  output rrpc_pkg::hue_beat_t           hue_beat
);

  localparam int unsigned PosCount = 2 ** rrpc_pkg::POS_W;

  logic [rrpc_pkg::HUE_W-1:0] outer_tab [PosCount];
  logic [rrpc_pkg::HUE_W-1:0] inner_tab [PosCount];
  logic [rrpc_pkg::HUE_W-1:0] base_hue;
  logic [rrpc_pkg::HUE_W-1:0] hue;
  logic                       valid;

  // position*256/ring_size, low byte only since the hue wraps anyway
  for (genvar gi = 0; gi < PosCount; gi++) begin : g_tab
    localparam logic [rrpc_pkg::HUE_W-1:0] OuterQ =
      rrpc_pkg::HUE_W'((gi * rrpc_pkg::HUE_STEPS) / OUTER_RING_LEDS);
    localparam logic [rrpc_pkg::HUE_W-1:0] InnerQ =
      rrpc_pkg::HUE_W'((gi * rrpc_pkg::HUE_STEPS) / INNER_RING_LEDS);
    assign outer_tab[gi] = OuterQ;
    assign inner_tab[gi] = InnerQ;
  end

  assign base_hue = ring_select ? inner_tab[led_position] : outer_tab[led_position];

  // stage 1 register, add wraps mod 256
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    hue <= base_hue + hue_offset;
  end

  assign hue_beat.valid = valid;
  assign hue_beat.hue   = hue;

endmodule

[hdl/rrpc_hsv.sv]
// hsv to rgb pipeline: sector split, saturation products, value products, channel select
// depends on rrpc_pkg and rainbow_ring_pixel_color_unit_macros.svh
`include "rainbow_ring_pixel_color_unit_macros.svh"
module rrpc_hsv (
  input  logic                        clk,
  input  logic                        rst,
  input  rrpc_pkg::hue_beat_t         hue_beat,
  input  rrpc_pkg::cfg_t              cfg,
  output logic                        done,
  output logic [rrpc_pkg::CH_W-1:0]   red,
  output logic [rrpc_pkg::CH_W-1:0]   green,
  output logic [rrpc_pkg::CH_W-1:0]   blue
);

  localparam int unsigned CW = rrpc_pkg::CH_W;
  localparam int unsigned PW = 2 * rrpc_pkg::CH_W;

  // stage 2 signals
  rrpc_pkg::sector_t   sec_c;
  logic [CW-1:0]       base_c;
  logic [CW:0]         rem_full;
  logic                v2;
  rrpc_pkg::sector_t   sec2;
  logic [CW-1:0]       rem2;

  // stage 3 signals
  logic [PW-1:0]       sq_prod;
  logic [PW-1:0]       st_prod;
  logic                v3;
  rrpc_pkg::sector_t   sec3;
  logic [CW-1:0]       sq3;
  logic [CW-1:0]       st3;

  // stage 4 signals
  logic [PW-1:0]       p_prod;
  logic [PW-1:0]       q_prod;
  logic [PW-1:0]       t_prod;
  logic                v4;
  rrpc_pkg::sector_t   sec4;
  logic [CW-1:0]       p4;
  logic [CW-1:0]       q4;
  logic [CW-1:0]       t4;
  logic [CW-1:0]       val4;
  logic                grey4;

  // stage 5 select
  logic [CW-1:0]       red_next;
  logic [CW-1:0]       green_next;
  logic [CW-1:0]       blue_next;

  // sector by compare chain, remainder scaled by six
  always_comb begin
    sec_c  = rrpc_pkg::SEC_RED;
    base_c = '0;
    if (hue_beat.hue >= CW'(5 * rrpc_pkg::SECTOR_SPAN)) begin
      sec_c  = rrpc_pkg::SEC_MAGENTA;
      base_c = CW'(5 * rrpc_pkg::SECTOR_SPAN);
    end else if (hue_beat.hue >= CW'(4 * rrpc_pkg::SECTOR_SPAN)) begin
      sec_c  = rrpc_pkg::SEC_BLUE;
      base_c = CW'(4 * rrpc_pkg::SECTOR_SPAN);
    end else if (hue_beat.hue >= CW'(3 * rrpc_pkg::SECTOR_SPAN)) begin
      sec_c  = rrpc_pkg::SEC_CYAN;
      base_c = CW'(3 * rrpc_pkg::SECTOR_SPAN);
    end else if (hue_beat.hue >= CW'(2 * rrpc_pkg::SECTOR_SPAN)) begin
      sec_c  = rrpc_pkg::SEC_GREEN;
      base_c = CW'(2 * rrpc_pkg::SECTOR_SPAN);
    end else if (hue_beat.hue >= CW'(rrpc_pkg::SECTOR_SPAN)) begin
      sec_c  = rrpc_pkg::SEC_YELLOW;
      base_c = CW'(rrpc_pkg::SECTOR_SPAN);
    end
  end

  assign rem_full = (CW+1)'(hue_beat.hue - base_c) * (CW+1)'(rrpc_pkg::REM_SCALE);

  // saturation products
  assign sq_prod = PW'(cfg.saturation) * PW'(rem2);
  assign st_prod = PW'(cfg.saturation) * PW'(rrpc_pkg::CH_MAX - rem2);

  // value products
  assign p_prod = PW'(cfg.brightness) * PW'(rrpc_pkg::CH_MAX - cfg.saturation);
  assign q_prod = PW'(cfg.brightness) * PW'(rrpc_pkg::CH_MAX - sq3);
  assign t_prod = PW'(cfg.brightness) * PW'(rrpc_pkg::CH_MAX - st3);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v2   <= hue_beat.valid;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    sec2  <= sec_c;
    rem2  <= rem_full[CW-1:0];
    sec3  <= sec2;
    sq3   <= sq_prod[PW-1:CW];
    st3   <= st_prod[PW-1:CW];
    sec4  <= sec3;
    p4    <= p_prod[PW-1:CW];
    q4    <= q_prod[PW-1:CW];
    t4    <= t_prod[PW-1:CW];
    val4  <= cfg.brightness;
    grey4 <= (cfg.saturation == '0);
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  // channel select per sector, grey when saturation is zero
  always_comb begin
    red_next   = val4;
    green_next = t4;
    blue_next  = p4;
    if (grey4) begin
      green_next = val4;
      blue_next  = val4;
    end else begin
      case (sec4)
        rrpc_pkg::SEC_YELLOW: begin
          red_next = q4; green_next = val4; blue_next = p4;
        end
        rrpc_pkg::SEC_GREEN: begin
          red_next = p4; green_next = val4; blue_next = t4;
        end
        rrpc_pkg::SEC_CYAN: begin
          red_next = p4; green_next = q4; blue_next = val4;
        end
        rrpc_pkg::SEC_BLUE: begin
          red_next = t4; green_next = p4; blue_next = val4;
        end
        rrpc_pkg::SEC_MAGENTA: begin
          red_next = val4; green_next = p4; blue_next = q4;
        end
        default: begin
          red_next = val4; green_next = t4; blue_next = p4;
        end
      endcase
    end
  end

  // checks
  `RRPC_ASSERT_NOW(a_done_from_stage3, done, $past(v3, 2), "result without a stage 3 beat")
  `RRPC_ASSERT_NOW(a_one_channel_full, done,
    (red == $past(val4)) || (green == $past(val4)) || (blue == $past(val4)),
    "no channel carries the value")
  `RRPC_ASSERT_NOW(a_grey_equal, done && $past(grey4),
    (red == green) && (green == blue), "grey result with unequal channels")

endmodule

[hdl/rainbow_ring_pixel_color_unit.sv]
// Rainbow ring pixel color unit, top level.
// Pixel beats enter on start; busy is never raised, so a beat may enter every cycle.
// Each beat carries ring_select, led_position and hue_offset; the hue is
// led_position*256/ring_size + hue_offset mod 256, converted to rgb with the
// six-sector integer hsv scheme at the brightness and saturation registers.
// The result appears on red, green and blue for one cycle with done high;
// throughput is one beat per cycle.
// The depth comes from five register stages: hue table and offset add,
// sector split, saturation products, value products, channel select.
// The receiver cannot stall: done is a strobe, results are not held.
// Registers sit on an apb port: brightness at 0x0 (reset 4), saturation at 0x4
// (reset 255). Write them only while no beat is in flight.
// Reset is synchronous and active high; it drops all beats in flight.
// Depends on rrpc_pkg, rrpc_regs, rrpc_hue and rrpc_hsv.
module rainbow_ring_pixel_color_unit #(
  parameter int unsigned OUTER_RING_LEDS = rrpc_pkg::OUTER_RING_LEDS_DEF,
  parameter int unsigned INNER_RING_LEDS = rrpc_pkg::INNER_RING_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          ring_select,
  input  logic [rrpc_pkg::POS_W-1:0]    led_position,
  input  logic [rrpc_pkg::HUE_W-1:0]    hue_offset,
  output logic                          done,
  output logic [rrpc_pkg::CH_W-1:0]     red,
  output logic [rrpc_pkg::CH_W-1:0]     green,
  output logic [rrpc_pkg::CH_W-1:0]     blue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  rrpc_pkg::cfg_t      cfg;
  rrpc_pkg::hue_beat_t hue_beat;
  logic                accept;

  // fully pipelined, never holds off a beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rrpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rrpc_hue #(
    .OUTER_RING_LEDS (OUTER_RING_LEDS),
    .INNER_RING_LEDS (INNER_RING_LEDS)
  ) u_hue (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .ring_select  (ring_select),
    .led_position (led_position),
    .hue_offset   (hue_offset),
    .hue_beat     (hue_beat)
  );

  rrpc_hsv u_hsv (
    .clk      (clk),
    .rst      (rst),
    .hue_beat (hue_beat),
    .cfg      (cfg),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule
